// ----- rtl/mrd_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// response deframer. No dependencies.
package mrd_pkg;

  localparam int unsigned MAX_PDU_BYTES = 64;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned IDX_W = 6;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PDU_BYTES);

  typedef struct packed {
    logic       frame_start;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       pdu_byte;
    logic             pdu_valid;
    logic [IDX_W-1:0] pdu_index;
    logic             frame_complete;
    logic             crc_match;
  } result_t;

  // Reflected CRC-16, one byte, bit by bit.
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrd_in_reg.sv -----
// Input register of the deframer: holds one accepted item until the core
// takes it. Depends on mrd_pkg.
module mrd_in_reg
  import mrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     held_valid,
  output in_item_t held_item
);

  logic load;

  assign in_ready = !held_valid || advance;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule

// ----- rtl/mrd_core.sv -----
// Frame tracking core: length register, CRC accumulator, byte position and
// the result of one byte. Depends on mrd_pkg.
module mrd_core
  import mrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             advance,
  input  in_item_t         item,
  output result_t          result
);

  logic [LEN_W-1:0] pdu_length;
  logic [15:0]      crc;
  logic [LEN_W-1:0] byte_position;
  logic [7:0]       received_crc_low;

  logic [15:0]      crc_next;
  logic [LEN_W-1:0] byte_position_next;
  logic [7:0]       received_crc_low_next;
  logic [LEN_W-1:0] len;
  logic [15:0]      crc_base;
  logic [LEN_W-1:0] pos;
  logic [15:0]      crc_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pdu_length <= LEN_MIN;
    end else if (cfg_wen) begin
      pdu_length <= cfg_wdata;
    end
  end

  always_comb begin
    if (pdu_length < LEN_MIN) begin
      len = LEN_MIN;
    end else if (pdu_length > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = pdu_length;
    end
  end

  assign crc_base = item.frame_start ? CRC_INIT : crc;
  assign pos      = item.frame_start ? '0 : byte_position;
  assign crc_upd  = crc_add_byte(crc_base, item.rx_byte);

  always_comb begin
    crc_next              = crc_base;
    byte_position_next    = pos;
    received_crc_low_next = received_crc_low;
    result                = '0;
    priority if (pos == '0) begin
      crc_next           = crc_upd;
      byte_position_next = LEN_W'(1);
    end else if (pos <= len) begin
      crc_next           = crc_upd;
      result.pdu_byte    = item.rx_byte;
      result.pdu_valid   = 1'b1;
      result.pdu_index   = IDX_W'(pos - LEN_W'(1));
      byte_position_next = pos + LEN_W'(1);
    end else if (pos == len + LEN_W'(1)) begin
      received_crc_low_next = item.rx_byte;
      byte_position_next    = pos + LEN_W'(1);
    end else if (pos == len + LEN_W'(2)) begin
      result.frame_complete = 1'b1;
      result.crc_match      = (received_crc_low == crc_base[7:0]) &&
                              (item.rx_byte == crc_base[15:8]);
      byte_position_next    = pos + LEN_W'(1);
    end else begin
      byte_position_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc              <= CRC_INIT;
      byte_position    <= '0;
      received_crc_low <= '0;
    end else if (advance) begin
      crc              <= crc_next;
      byte_position    <= byte_position_next;
      received_crc_low <= received_crc_low_next;
    end
  end

endmodule

// ----- rtl/mrd_out_reg.sv -----
// Result register of the deframer: holds one result until the receiver
// takes it. Depends on mrd_pkg.
module mrd_out_reg
  import mrd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  output logic    slot_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t held
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ----- rtl/modbus_rtu_response_deframer_top.sv -----
// Modbus RTU response deframer with CRC-16 check, top level.
// Usage:
//   s_axis carries received frame bytes; tuser set marks the address byte
//   of a new frame. Every accepted byte yields exactly one item on m_axis:
//   the PDU byte and its index (tuser[0] set when the byte lies in the PDU),
//   or, on the last CRC byte, tlast with tuser[1] giving the CRC result.
//   The address byte, the first CRC byte and bytes after the frame end yield all-zero items.
//   cfg_wen/cfg_wdata set the PDU length (1..64, out-of-range values are
//   clamped); write it only while the block is idle.
// Timing:
//   One byte per cycle sustained while the receiver takes every result. A
//   byte is held in an input register, then the CRC update and position
//   logic run combinationally from it into the result register, where the
//   receiver takes it.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; s_axis_tready drops after that.
// Reset:
//   rst clears both registers, the CRC to 0xFFFF, the byte count to zero
//   and the PDU length to 1.
// Depends on mrd_pkg, mrd_in_reg, mrd_core, mrd_out_reg.
module modbus_rtu_response_deframer_top
  import mrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] rx_byte
  input  logic             s_axis_tuser,  // [0] frame_start
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [7:0] pdu_byte, [13:8] pdu_index, rest 0
  output logic [1:0]       m_axis_tuser,  // [0] pdu_valid, [1] crc_match
  output logic             m_axis_tlast   // frame_complete
);

  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     slot_free;
  logic     advance;
  result_t  result;
  result_t  out_item;

  assign in_item.rx_byte     = s_axis_tdata;
  assign in_item.frame_start = s_axis_tuser;
  assign advance             = held_valid && slot_free;

  mrd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mrd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (held_item),
    .result    (result)
  );

  mrd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .slot_free (slot_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .held      (out_item)
  );

  assign m_axis_tdata = {2'b00, out_item.pdu_index, out_item.pdu_byte};
  assign m_axis_tuser = {out_item.crc_match, out_item.pdu_valid};
  assign m_axis_tlast = out_item.frame_complete;

endmodule

// ----- tb/mrd_frame_checker.sv -----
// Result checker for the Modbus RTU response deframer: follows the length
// register and both streams, predicts every result item and compares it.
// Depends on mrd_pkg.
module mrd_frame_checker
  import mrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,
  input  logic             s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [15:0]      m_axis_tdata,
  input  logic [1:0]       m_axis_tuser,
  input  logic             m_axis_tlast,
  output int               fail_count,
  output int               expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LEN_W-1:0] pdu_length;
  logic [15:0]      crc_run;
  int unsigned      frame_pos;
  logic [7:0]       crc_low_seen;
  result_t          expected_q[$];
  int               errors = 0;

  initial begin
    fail_count = 0;
    expected_left = 0;
  end

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic int unsigned active_length();
    int unsigned n;
    n = pdu_length;
    if (n < 1) begin
      n = 1;
    end
    if (n > MAX_PDU_BYTES) begin
      n = MAX_PDU_BYTES;
    end
    return n;
  endfunction

  function automatic result_t deframe(input logic [7:0] b, input logic start);
    result_t     r;
    int unsigned n;
    r = '0;
    n = active_length();
    if (start) begin
      crc_run = CRC_INIT;
      frame_pos = 0;
    end
    if (frame_pos == 0) begin
      crc_run = crc16_fold(crc_run, b);
      frame_pos = 1;
    end else if (frame_pos <= n) begin
      crc_run = crc16_fold(crc_run, b);
      r.pdu_byte = b;
      r.pdu_valid = 1'b1;
      r.pdu_index = IDX_W'(frame_pos - 1);
      frame_pos++;
    end else if (frame_pos == n + 1) begin
      crc_low_seen = b;
      frame_pos++;
    end else if (frame_pos == n + 2) begin
      r.frame_complete = 1'b1;
      r.crc_match = (crc_low_seen == crc_run[7:0]) && (b == crc_run[15:8]);
      frame_pos++;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      pdu_length = LEN_MIN;
      crc_run = CRC_INIT;
      frame_pos = 0;
      crc_low_seen = '0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result item expected none actual tdata %0h tuser %0h tlast %0b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("pdu_byte", want.pdu_byte, m_axis_tdata[7:0]);
          check_field("pdu_index", want.pdu_index, m_axis_tdata[13:8]);
          check_field("tdata reserved bits", 0, m_axis_tdata[15:14]);
          check_field("pdu_valid", want.pdu_valid, m_axis_tuser[0]);
          check_field("crc_match", want.crc_match, m_axis_tuser[1]);
          check_field("frame_complete", want.frame_complete, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(deframe(s_axis_tdata, s_axis_tuser));
      end
      if (cfg_wen) begin
        pdu_length = cfg_wdata;
      end
    end
    fail_count <= errors;
    expected_left <= expected_q.size();
  end

endmodule

// ----- tb/tb_modbus_rtu_response_deframer_top.sv -----
// Testbench top for the Modbus RTU response deframer: drives frames, noise
// and length settings, paces both streams and reports the verdict.
// Depends on mrd_pkg, modbus_rtu_response_deframer_top and mrd_frame_checker.
module tb_modbus_rtu_response_deframer_top;
  import mrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 45;
  localparam int LONG_HOLD = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {FRAME_GOOD, FRAME_BAD_LOW, FRAME_BAD_HIGH, FRAME_CUT} frame_kind_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wen = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;

  int fail_count;
  int expected_left;
  int quiet_cycles = 0;
  int phase_items = 0;
  int holds_asked = 0;
  int holds_granted = 0;
  bit calm = 1'b0;
  bit sender_gaps = 1'b1;

  always #1 clk = ~clk;

  modbus_rtu_response_deframer_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  mrd_frame_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** modbus_rtu_response_deframer_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_granted != holds_asked) begin
        holds_granted++;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic start);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    phase_items++;
    if (!calm && sender_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // fill < 0: random content; else every PDU byte is fill and the address its inverse
  task automatic send_frame(input int n, input frame_kind_t kind, input logic lead,
                            input int fill, input int extra);
    logic [15:0] crc;
    logic [7:0]  b;
    logic [7:0]  lo;
    logic [7:0]  hi;
    int          upto;
    b = (fill < 0) ? 8'($urandom) : ~8'(fill);
    send_item(b, lead);
    crc = crc_add_byte(CRC_INIT, b);
    upto = (kind == FRAME_CUT) ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < upto; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      send_item(b, 1'b0);
      crc = crc_add_byte(crc, b);
    end
    if (kind != FRAME_CUT) begin
      lo = crc[7:0];
      hi = crc[15:8];
      if (kind == FRAME_BAD_LOW) begin
        lo ^= 8'($urandom_range(1, 255));
      end
      if (kind == FRAME_BAD_HIGH) begin
        hi ^= 8'($urandom_range(1, 255));
      end
      send_item(lo, 1'b0);
      send_item(hi, 1'b0);
      for (int i = 0; i < extra; i++) begin
        send_item(8'($urandom), 1'b0);
      end
    end
  endtask

  // drain all results, then let the pipeline settle before the write
  task automatic set_length(input logic [LEN_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    logic [LEN_W-1:0] lengths[8];
    int               eff;
    lengths = '{7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd1, 7'd3, 7'd7};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(1, FRAME_GOOD, 1'b0, 8'hFF, 2);
    send_frame(1, FRAME_BAD_LOW, 1'b1, 8'h00, 0);
    send_frame(1, FRAME_BAD_HIGH, 1'b1, -1, 0);
    send_item(8'h5A, 1'b1);
    send_item(8'hA5, 1'b0);
    send_frame(1, FRAME_GOOD, 1'b1, -1, 1);

    foreach (lengths[p]) begin
      set_length(lengths[p]);
      eff = (lengths[p] == 0) ? 1 : (lengths[p] > MAX_PDU_BYTES) ? MAX_PDU_BYTES : lengths[p];
      calm = (p == 7);
      sender_gaps = ($urandom_range(0, 2) != 0);
      if (lengths[p] == LEN_MAX) begin
        holds_asked++;
      end
      phase_items = 0;
      // continue whatever frame was open before the length changed
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
      end
      while (phase_items < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_frame(eff, FRAME_GOOD, 1'b1, -1, 0);
          5: send_frame(eff, FRAME_GOOD, 1'b1, -1, $urandom_range(1, 3));
          6: send_frame(eff, $urandom_range(0, 1) ? FRAME_BAD_LOW : FRAME_BAD_HIGH,
                        1'b1, -1, 0);
          7: send_frame(eff, FRAME_CUT, 1'b1, -1, 0);
          8: send_frame((eff == 1) ? 2 : eff + ($urandom_range(0, 1) ? 1 : -1),
                        FRAME_GOOD, 1'b1, -1, 0);
          default: begin
            repeat ($urandom_range(1, 6)) send_item(8'($urandom), $urandom_range(0, 3) == 0);
          end
        endcase
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("** modbus_rtu_response_deframer_top: PASSED **");
    end else begin
      $display("** modbus_rtu_response_deframer_top: FAILED **");
    end
    $finish;
  end

endmodule
